### hdl/chr_pkg.sv
// Shared types and constants for the consistent hash ring.
package chr_pkg;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_DEL  = 2'd1;
   localparam logic [1:0] KIND_LOOK = 2'd2;
   localparam logic [1:0] KIND_PREF = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_NO_PREF = 2'd2;

   localparam logic [0:0] CSR_REPLICA_COUNT = 1'd0;
   localparam logic [0:0] CSR_SPREAD_FACTOR = 1'd1;

   localparam logic [6:0]  REPLICA_RESET = 7'd16;
   localparam logic [6:0]  MAX_REPLICAS  = 7'd64;
   localparam logic [31:0] SPREAD_RESET  = 32'd2654435761;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_BASE,
      S_MUL_REP,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_NEXT,
      S_WALK_RD,
      S_WALK_CMP,
      S_DONE
   } state_type;

endpackage

### hdl/chr_ram.sv
// Generic single-port RAM with registered read.
module chr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/consistent_hash_ring.sv
// Top level of the consistent hash ring: sequencer, shared compare unit and slot RAMs.
//
// Usage: pulse start with kind, node_id, node_hash and key_hash while busy is low.
// busy rises on the next cycle and stays high through the single result beat, marked
// by rsp_valid, which appears for exactly one cycle on the rsp_ ports; busy falls on
// the cycle after it. The receiver cannot stall: every result is taken as it shows.
// Lookup: a binary search over the sorted slot RAM, each halving a RAM read then a
// compare. Preference adds a backward walk, one RAM read and compare per slot visited.
// Add and delete: one base multiply, then per replica a multiply, the search, a decide
// step, a move of one entry per RAM read and write for every slot at or above the insert
// point or above the delete point, a put step and a next step. Each store has a single
// RAM port. Configuration writes on the csr_ port take effect at once; the user must
// make them only while busy is low, which the block itself does not enforce.
// Synchronous reset empties the ring (slot count zero) and restores replica_count 16
// and spread_factor 2654435761; the RAMs are not cleared.
module consistent_hash_ring
   import chr_pkg::*;
#(
   parameter int CAPACITY  = 256,
   parameter int NODE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_node_id,
   input  logic [31:0] req_node_hash,
   input  logic [31:0] req_key_hash,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_owner_id,
   output logic [31:0] rsp_slot_position,
   output logic [6:0]  rsp_replicas_placed,
   output logic [6:0]  rsp_replicas_skipped,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   logic [6:0]  rep_cnt_ff;
   logic [31:0] spread_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  kind_ff;
   logic [NODE_BITS-1:0] node_ff;
   logic [31:0] nhash_ff, key_ff;
   logic [31:0] base_ff, base_in;
   logic [31:0] pos_ff, pos_in;
   logic [6:0]  rep_i_ff, rep_i_in, reps_ff;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in, walk_ff, walk_in;
   logic [NODE_BITS-1:0] self_ff, self_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  owner_ff, owner_in;
   logic [31:0] spos_ff, spos_in;
   logic [6:0]  placed_ff, placed_in, skipped_ff, skipped_in;
   logic        hit;

   logic        ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0] ram_wpos, ram_rpos;
   logic [NODE_BITS-1:0] ram_wown, ram_rown;
   logic [31:0] srch_key;
   logic [CW-1:0] mid;
   logic [63:0] prod;

   logic [31:0] mul_a, mul_b;

   chr_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_pos_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wpos), .rd_data(ram_rpos));

   chr_ram #(.WIDTH(NODE_BITS), .DEPTH(CAPACITY)) u_own_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wown), .rd_data(ram_rown));

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign srch_key = (kind_ff == KIND_ADD || kind_ff == KIND_DEL) ? pos_ff : key_ff;
   assign mul_a    = (state_ff == S_MUL_BASE) ? nhash_ff : base_ff;
   assign mul_b    = (state_ff == S_MUL_BASE) ? spread_ff : {25'd0, rep_i_ff};
   assign prod     = mul_a * mul_b;
   assign hit      = (lo_ff < count_ff) && (ram_rpos == srch_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rep_cnt_ff <= REPLICA_RESET;
         spread_ff  <= SPREAD_RESET;
         count_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en && csr_index == CSR_REPLICA_COUNT) begin
            rep_cnt_ff <= csr_wr_data[6:0];
         end
         if (csr_wr_en && csr_index == CSR_SPREAD_FACTOR) begin
            spread_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         kind_ff  <= req_kind;
         node_ff  <= req_node_id[NODE_BITS-1:0];
         nhash_ff <= req_node_hash;
         key_ff   <= req_key_hash;
         reps_ff  <= (rep_cnt_ff > MAX_REPLICAS) ? MAX_REPLICAS : rep_cnt_ff;
      end
      base_ff    <= base_in;
      pos_ff     <= pos_in;
      rep_i_ff   <= rep_i_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      ptr_ff     <= ptr_in;
      walk_ff    <= walk_in;
      self_ff    <= self_in;
      status_ff  <= status_in;
      owner_ff   <= owner_in;
      spos_ff    <= spos_in;
      placed_ff  <= placed_in;
      skipped_ff <= skipped_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_kind == KIND_ADD || req_kind == KIND_DEL) begin
                  state_in = S_MUL_BASE;
               end else if (count_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_MUL_BASE: begin
            state_in = (reps_ff == 7'd0) ? S_DONE : S_MUL_REP;
         end
         S_MUL_REP:  state_in = S_SRCH_RD;
         S_SRCH_RD:  state_in = (lo_ff < hi_ff) ? S_SRCH_CMP : S_DECIDE;
         S_SRCH_CMP: state_in = S_SRCH_RD;
         S_DECIDE: begin
            case (kind_ff)
               KIND_ADD: begin
                  if (hit || count_ff >= CW'(CAPACITY)) begin
                     state_in = S_NEXT;
                  end else begin
                     state_in = (count_ff > lo_ff) ? S_SHIFT_RD : S_PUT;
                  end
               end
               KIND_DEL: begin
                  if (hit && ram_rown == node_ff) begin
                     state_in = (lo_ff + CW'(1) < count_ff) ? S_SHIFT_RD : S_PUT;
                  end else begin
                     state_in = S_NEXT;
                  end
               end
               KIND_LOOK: state_in = S_DONE;
               default: begin
                  state_in = (hit && count_ff > CW'(1)) ? S_WALK_RD : S_DONE;
               end
            endcase
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (kind_ff == KIND_ADD) begin
               state_in = (ptr_ff - CW'(1) > lo_ff) ? S_SHIFT_RD : S_PUT;
            end else begin
               state_in = (ptr_ff + CW'(2) < count_ff) ? S_SHIFT_RD : S_PUT;
            end
         end
         S_PUT: state_in = S_NEXT;
         S_NEXT: state_in = (rep_i_ff == reps_ff) ? S_DONE : S_MUL_REP;
         S_WALK_RD: state_in = S_WALK_CMP;
         S_WALK_CMP: begin
            if (ram_rown != self_ff || walk_ff == CW'(1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      base_in    = base_ff;
      pos_in     = pos_ff;
      rep_i_in   = rep_i_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      ptr_in     = ptr_ff;
      walk_in    = walk_ff;
      self_in    = self_ff;
      status_in  = status_ff;
      owner_in   = owner_ff;
      spos_in    = spos_ff;
      placed_in  = placed_ff;
      skipped_in = skipped_ff;
      count_in   = count_ff;
      ram_we     = 1'b0;
      ram_addr   = mid[AW-1:0];
      ram_wpos   = ram_rpos;
      ram_wown   = ram_rown;
      case (state_ff)
         S_IDLE: begin
            status_in  = (count_ff == '0) ? ST_EMPTY : ST_OK;
            owner_in   = '0;
            spos_in    = '0;
            placed_in  = '0;
            skipped_in = '0;
            rep_i_in   = 7'd1;
            lo_in      = '0;
            hi_in      = count_ff;
            if (req_kind == KIND_ADD || req_kind == KIND_DEL) begin
               status_in = ST_OK;
            end
         end
         S_MUL_BASE: begin
            base_in = prod[31:0];
         end
         S_MUL_REP: begin
            pos_in = prod[31:0];
            lo_in  = '0;
            hi_in  = count_ff;
         end
         S_SRCH_RD: begin
            ram_addr = (lo_ff < hi_ff) ? mid[AW-1:0] : lo_ff[AW-1:0];
         end
         S_SRCH_CMP: begin
            if (ram_rpos < srch_key) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
         end
         S_DECIDE: begin
            case (kind_ff)
               KIND_ADD: begin
                  ptr_in = count_ff;
                  if (hit || count_ff >= CW'(CAPACITY)) begin
                     skipped_in = skipped_ff + 7'd1;
                  end
               end
               KIND_DEL: begin
                  ptr_in = lo_ff;
                  if (!(hit && ram_rown == node_ff)) begin
                     skipped_in = skipped_ff + 7'd1;
                  end
               end
               KIND_LOOK: begin
                  if (lo_ff >= count_ff) begin
                     lo_in   = '0;
                     ptr_in  = '0;
                  end else begin
                     owner_in = 8'(ram_rown);
                     spos_in  = ram_rpos;
                  end
               end
               default: begin
                  self_in = ram_rown;
                  ptr_in  = lo_ff;
                  walk_in = count_ff - CW'(1);
                  if (!hit || count_ff <= CW'(1)) begin
                     status_in = ST_NO_PREF;
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            ram_addr = (kind_ff == KIND_ADD) ? AW'(ptr_ff - CW'(1)) : AW'(ptr_ff + CW'(1));
         end
         S_SHIFT_WR: begin
            ram_we   = 1'b1;
            ram_addr = ptr_ff[AW-1:0];
            ptr_in   = (kind_ff == KIND_ADD) ? ptr_ff - CW'(1) : ptr_ff + CW'(1);
         end
         S_PUT: begin
            if (kind_ff == KIND_ADD) begin
               ram_we    = 1'b1;
               ram_addr  = lo_ff[AW-1:0];
               ram_wpos  = pos_ff;
               ram_wown  = node_ff;
               count_in  = count_ff + CW'(1);
            end else begin
               count_in  = count_ff - CW'(1);
            end
            placed_in = placed_ff + 7'd1;
         end
         S_NEXT: begin
            rep_i_in = rep_i_ff + 7'd1;
         end
         S_WALK_RD: begin
            ptr_in   = (ptr_ff == '0) ? count_ff - CW'(1) : ptr_ff - CW'(1);
            ram_addr = (ptr_ff == '0) ? AW'(count_ff - CW'(1)) : AW'(ptr_ff - CW'(1));
         end
         S_WALK_CMP: begin
            walk_in = walk_ff - CW'(1);
            if (ram_rown != self_ff) begin
               owner_in = 8'(ram_rown);
               spos_in  = ram_rpos;
            end else if (walk_ff == CW'(1)) begin
               status_in = ST_NO_PREF;
            end
         end
         default: begin
         end
      endcase
   end

   // Lookup wrap: rather than re-read slot zero in DONE, slot zero is mirrored below on
   // every write to it and shown when a lookup wraps past the last slot.
   logic [31:0] first_pos_ff;
   logic [NODE_BITS-1:0] first_own_ff;
   logic wrap_ff;

   always_ff @(posedge clock) begin
      if (ram_we && ram_addr == '0) begin
         first_pos_ff <= ram_wpos;
         first_own_ff <= ram_wown;
      end
      if (state_ff == S_DECIDE) begin
         wrap_ff <= (kind_ff == KIND_LOOK) && (lo_ff >= count_ff);
      end else if (state_ff == S_IDLE) begin
         wrap_ff <= 1'b0;
      end
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_DONE);
   assign rsp_status           = status_ff;
   assign rsp_owner_id         = wrap_ff ? 8'(first_own_ff) : owner_ff;
   assign rsp_slot_position    = wrap_ff ? first_pos_ff : spos_ff;
   assign rsp_replicas_placed  = placed_ff;
   assign rsp_replicas_skipped = skipped_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("slot count above capacity");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held more than one cycle");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> $stable(count_ff))
      else $error("slot count changed while idle");
`endif

endmodule
